// ----- rtl/assert_macros.svh -----
// assertion helpers, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// clocked property, ignored while reset is high
`define FRBE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frbe assertion failed");

// clocked property, checked during reset as well
`define FRBE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frbe assertion failed");

`else

`define FRBE_ASSERT(lbl, clk, rst, prop)
`define FRBE_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/frbe_pkg.sv -----
package frbe_pkg;

  localparam int WINDOW_DEF = 15;

  localparam int DUR_W  = 32;
  localparam int MIN_W  = 4;
  localparam int FPS_W  = 20;
  localparam int QUO_W  = 20;
  localparam int DEN_W  = DUR_W + 1;
  localparam int DSH_W  = DEN_W + QUO_W - 1;
  localparam int QCNT_W = $clog2(QUO_W);

  localparam logic [MIN_W-1:0] MIN_SAMPLES_RST = MIN_W'(3);
  localparam logic [DEN_W-1:0] FPS_NUM         = DEN_W'(2000000);
  localparam logic [FPS_W-1:0] FPS_MAX         = FPS_W'(1000000);

  localparam logic KIND_SAMPLE  = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_LO,
    S_LO_WAIT,
    S_HI,
    S_HI_WAIT,
    S_DONE
  } frbe_state_t;

  typedef struct packed {
    logic clear;
    logic rd_en;
  } frbe_win_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } frbe_div_sts_t;

endpackage

// ----- rtl/frbe_sample_if.sv -----
interface frbe_sample_if;
  import frbe_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [DUR_W-1:0] duration_us;

  modport source (output valid, output kind, output duration_us, input ready);
  modport sink   (input valid, input kind, input duration_us, output ready);
endinterface

// ----- rtl/frbe_result_if.sv -----
interface frbe_result_if;
  import frbe_pkg::*;

  logic             valid;
  logic             ready;
  logic             fps_valid;
  logic [FPS_W-1:0] fps_bucket;

  modport source (output valid, output fps_valid, output fps_bucket, input ready);
  modport sink   (input valid, input fps_valid, input fps_bucket, output ready);
endinterface

// ----- rtl/frbe_cfg_if.sv -----
interface frbe_cfg_if;
  import frbe_pkg::*;

  logic             valid;
  logic             ready;
  logic [MIN_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/frbe_window.sv -----
module frbe_window #(
  parameter int Window = frbe_pkg::WINDOW_DEF,
  parameter int SlotW  = $clog2(Window)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  frbe_pkg::frbe_win_ctl_t     ctl,
  input  logic [SlotW-1:0]            rd_addr,
  input  logic                        wr_en,
  input  logic [SlotW-1:0]            wr_addr,
  input  logic [frbe_pkg::DUR_W-1:0]  wr_data,
  output logic [frbe_pkg::DUR_W-1:0]  lo,
  output logic [frbe_pkg::DUR_W-1:0]  hi
);
  import frbe_pkg::*;

  logic [DUR_W-1:0] mem [Window];
  logic [DUR_W-1:0] rd_data;
  logic             rd_vld;

  // duration ring, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= ctl.rd_en;
    end
  end

  // running min and max over the scanned entries
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      lo <= '1;
      hi <= '0;
    end else if (rd_vld) begin
      if (rd_data < lo) begin
        lo <= rd_data;
      end
      if (rd_data > hi) begin
        hi <= rd_data;
      end
    end
  end

endmodule

// ----- rtl/frbe_div.sv -----
module frbe_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [frbe_pkg::DUR_W-1:0]  dur,
  output frbe_pkg::frbe_div_sts_t     sts,
  output logic [frbe_pkg::FPS_W-1:0]  quo
);
  import frbe_pkg::*;

  `include "assert_macros.svh"

  logic [DEN_W-1:0]  rem;
  logic [DSH_W-1:0]  dsh;
  logic [QCNT_W-1:0] step;
  logic              busy;
  logic              done;
  logic              ge;

  // quotient stays below 2^QUO_W, so the shifted divisor starts at bit QUO_W-1
  assign ge = {{(DSH_W-DEN_W){1'b0}}, rem} >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == QCNT_W'(QUO_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= FPS_NUM + {1'b0, dur};
      dsh <= {dur, 1'b0, {(QUO_W-1){1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh[DEN_W-1:0];
      end
      dsh <= dsh >> 1;
      quo <= {quo[FPS_W-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

  `FRBE_ASSERT(a_start_busy, clk, rst, start |=> busy)
  `FRBE_ASSERT(a_done_ends, clk, rst, done |-> !busy && $past(busy))
  `FRBE_ASSERT(a_quo_range, clk, rst, done && $past(dur != '0) |-> quo <= FPS_MAX)

endmodule

// ----- rtl/frame_rate_bucket_estimator_core.sv -----
// Frame rate bucket estimator. Each sample item (kind 0) carries a frame
// duration in microseconds, a duration of 0 counting as 1; it is stored in a
// ring of Window entries and the sample count saturates at Window. Once the
// count reaches the requirement (min_samples, or Window after a disagreement
// has been seen) the ring is scanned for its shortest and longest duration,
// both are turned into fps buckets floor((2000000 + d) / (2 d)), and equal
// buckets give the estimate while unequal ones clear it and raise the
// requirement. A restart item (kind 1) clears the ring, the estimate and the
// raised requirement. Every item yields one result item with the current
// estimate. One item at a time is worked on: an item that needs no scan goes
// straight to the result register, while one that scans runs the
// one-entry-a-cycle read of the ring memory and two 20-step serial divisions
// on a shared divider. A waiting result does not stop the next item from being
// taken. min_samples is written through the cfg channel,
// which is always ready.
module frame_rate_bucket_estimator_core #(
  parameter int Window = frbe_pkg::WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst,
  frbe_sample_if.sink   sample,
  frbe_result_if.source estimate,
  frbe_cfg_if.sink      cfg
);
  import frbe_pkg::*;

  `include "assert_macros.svh"

  localparam int SlotW = $clog2(Window);
  localparam int CntW  = $clog2(Window + 1);
  localparam int CmpW  = (CntW > MIN_W) ? CntW : MIN_W;

  frbe_state_t state, state_next;

  // configuration
  logic [MIN_W-1:0] min_samples;

  // estimator state
  logic [SlotW-1:0] write_slot;
  logic [CntW-1:0]  sample_count;
  logic             requirement_raised;
  logic             estimate_valid;
  logic [FPS_W-1:0] estimate_value;

  // scan and division
  logic [SlotW-1:0] rd_addr;
  logic [FPS_W-1:0] bucket_lo;
  logic [DUR_W-1:0] win_lo;
  logic [DUR_W-1:0] win_hi;
  logic [FPS_W-1:0] div_quo;
  frbe_div_sts_t    div_sts;
  frbe_win_ctl_t    win_ctl;
  logic             div_start;

  // result register
  logic             res_valid;
  logic             res_fps_valid;
  logic [FPS_W-1:0] res_fps_bucket;

  // accept side
  logic             in_acc;
  logic             acc_sample;
  logic [DUR_W-1:0] dur_fix;
  logic [CntW-1:0]  count_inc;
  logic [CmpW-1:0]  need;
  logic             go_scan;
  logic             scan_last;
  logic             res_load;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples <= MIN_SAMPLES_RST;
    end else if (cfg.valid) begin
      min_samples <= cfg.data;
    end
  end

  assign in_acc     = sample.valid && sample.ready;
  assign acc_sample = in_acc && (sample.kind == KIND_SAMPLE);

  // zero duration counts as one microsecond
  assign dur_fix = (sample.duration_us == '0) ? DUR_W'(1) : sample.duration_us;

  // count after this sample, saturating at the window depth
  assign count_inc = (sample_count == CntW'(Window)) ? sample_count
                                                     : sample_count + CntW'(1);

  assign need    = requirement_raised ? CmpW'(Window) : CmpW'(min_samples);
  assign go_scan = CmpW'(count_inc) >= need;

  // last entry of the scan is count - 1 (entries 0 .. count - 1 hold samples)
  assign scan_last = CntW'(rd_addr) == (sample_count - CntW'(1));

  // result slot frees up when empty or being taken this cycle
  assign res_load = (state == S_DONE) && (!res_valid || estimate.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    win_ctl      = '0;
    div_start    = 1'b0;
    unique case (state)
      // ready is high here, so valid alone marks the accepted item
      S_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) begin
          if ((sample.kind == KIND_SAMPLE) && go_scan) begin
            win_ctl.clear = 1'b1;
            state_next    = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        win_ctl.rd_en = 1'b1;
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // last read lands in the min/max registers
      S_DRAIN: begin
        state_next = S_LO;
      end
      S_LO: begin
        div_start  = 1'b1;
        state_next = S_LO_WAIT;
      end
      S_LO_WAIT: begin
        if (div_sts.done) begin
          state_next = S_HI;
        end
      end
      S_HI: begin
        div_start  = 1'b1;
        state_next = S_HI_WAIT;
      end
      S_HI_WAIT: begin
        if (div_sts.done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ring position, count and estimate
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot         <= '0;
      sample_count       <= '0;
      requirement_raised <= 1'b0;
      estimate_valid     <= 1'b0;
      estimate_value     <= '0;
    end else begin
      if (in_acc && (sample.kind == KIND_RESTART)) begin
        write_slot         <= '0;
        sample_count       <= '0;
        requirement_raised <= 1'b0;
        estimate_valid     <= 1'b0;
        estimate_value     <= '0;
      end else if (acc_sample) begin
        write_slot   <= (write_slot == SlotW'(Window - 1)) ? '0 : write_slot + SlotW'(1);
        sample_count <= count_inc;
      end
      // buckets of shortest and longest duration agree or not
      if ((state == S_HI_WAIT) && div_sts.done) begin
        if (bucket_lo != div_quo) begin
          estimate_valid     <= 1'b0;
          estimate_value     <= '0;
          requirement_raised <= 1'b1;
        end else begin
          estimate_valid <= 1'b1;
          estimate_value <= bucket_lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_addr <= '0;
    end else if (state == S_SCAN) begin
      rd_addr <= rd_addr + SlotW'(1);
    end
    if ((state == S_LO_WAIT) && div_sts.done) begin
      bucket_lo <= div_quo;
    end
  end

  frbe_window #(
    .Window (Window),
    .SlotW  (SlotW)
  ) u_window (
    .clk     (clk),
    .rst     (rst),
    .ctl     (win_ctl),
    .rd_addr (rd_addr),
    .wr_en   (acc_sample),
    .wr_addr (write_slot),
    .wr_data (dur_fix),
    .lo      (win_lo),
    .hi      (win_hi)
  );

  frbe_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dur   ((state == S_HI) ? win_hi : win_lo),
    .sts   (div_sts),
    .quo   (div_quo)
  );

  // result register parts the two sides
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (estimate.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_fps_valid  <= estimate_valid;
      res_fps_bucket <= estimate_valid ? estimate_value : '0;
    end
  end

  assign estimate.valid      = res_valid;
  assign estimate.fps_valid  = res_fps_valid;
  assign estimate.fps_bucket = res_fps_bucket;

  `FRBE_ASSERT(a_count_bound, clk, rst, sample_count <= CntW'(Window))
  `FRBE_ASSERT(a_slot_bound, clk, rst, write_slot <= SlotW'(Window - 1))
  `FRBE_ASSERT(a_restart_clears, clk, rst,
    in_acc && (sample.kind == KIND_RESTART) |=> !estimate_valid && !requirement_raised)
  `FRBE_ASSERT(a_invalid_zero, clk, rst,
    estimate.valid && !estimate.fps_valid |-> estimate.fps_bucket == '0)
  `FRBE_ASSERT(a_div_idle_outside, clk, rst,
    div_sts.busy |-> (state == S_LO_WAIT) || (state == S_HI_WAIT))

endmodule
